>>> rtl/tsfd_pkg.sv
// ----------------------------------------------------------------------------
// tsfd_pkg
// Shared constants, controller states and the command and status bundles
// passed between the deframer controller and its datapath.
// ----------------------------------------------------------------------------
package tsfd_pkg;

   // default frame store depth
   localparam int MAX_PAYLOAD_DEF = 20;

   // header marker byte
   localparam logic [7:0] STAR_BYTE = 8'h2A;

   // frames shorter than this are padded with zero bytes
   localparam int MIN_FRAME = 8;

   // width of the emitted byte position field
   localparam int IDX_W = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR1,
      ST_HDR2,
      ST_LEN,
      ST_DATA,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_count;
      logic load_len;
      logic store;
      logic emit_load;
      logic err_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_star;
      logic len_zero;
      logic len_over;
      logic frame_full;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

>>> rtl/tsfd_ctrl.sv
// ----------------------------------------------------------------------------
// tsfd_ctrl
// Parser and emit sequencer: walks the header, length and payload phases and
// steps the datapath through frame output.
// ----------------------------------------------------------------------------
module tsfd_ctrl
   import tsfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               state_in = status.is_star ? ST_HDR1 : ST_IDLE;
            end
         end
         ST_HDR1: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               state_in = status.is_star ? ST_HDR2 : ST_IDLE;
            end
         end
         ST_HDR2: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               state_in = status.is_star ? ST_LEN : ST_IDLE;
            end
         end
         ST_LEN: begin
            // an oversize length needs the output register
            req_ready = status.out_free;
            accept    = req_valid && status.out_free;
            if (accept && !status.is_star) begin
               cmd.clear_count = 1'b1;
               if (status.len_zero) begin
                  state_in = ST_IDLE;
               end else if (status.len_over) begin
                  cmd.err_load = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in     = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               cmd.store = 1'b1;
               if (status.frame_full) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // emit phase is only entered from the request that fills the frame
   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff) != ST_EMIT)
         |-> $past(cmd.store && status.frame_full))
      else $error("emit phase entered without a completed frame");

   // the final emitted byte returns the parser to idle
   a_emit_exit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && status.emit_last) |=> state_ff == ST_IDLE)
      else $error("parser did not return to idle after frame output");

endmodule

>>> rtl/tsfd_dp.sv
// ----------------------------------------------------------------------------
// tsfd_dp
// Frame store, length and count registers, emit index and the registered
// result stage.
// ----------------------------------------------------------------------------
module tsfd_dp
   import tsfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_rx_byte,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [7:0]       rsp_payload_byte,
   output logic [IDX_W-1:0] rsp_byte_index,
   output logic             rsp_last_byte,
   output logic             rsp_frame_error
);

   localparam int CW = $clog2(MAX_PAYLOAD + 1);
   localparam int AW = $clog2(MAX_PAYLOAD);

   logic [7:0]    frame_mem [MAX_PAYLOAD];

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] expected_ff;
   logic [CW-1:0] expected_in;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   logic [7:0]       rsp_payload_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic             rsp_last_ff;
   logic             rsp_error_ff;

   logic [CW-1:0]       total;
   logic [CW+IDX_W-1:0] idx_wide;

   // padded frame length
   assign total    = (count_ff < CW'(MIN_FRAME)) ? CW'(MIN_FRAME) : count_ff;
   assign idx_wide = {{IDX_W{1'b0}}, idx_ff};

   always_comb begin
      status.is_star    = (req_rx_byte == STAR_BYTE);
      status.len_zero   = (req_rx_byte == 8'd0);
      status.len_over   = (req_rx_byte > 8'(MAX_PAYLOAD));
      status.frame_full = ((count_ff + CW'(1)) == expected_ff);
      status.emit_last  = ((idx_ff + CW'(1)) == total);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.store) begin
         count_in = count_ff + CW'(1);
      end

      expected_in = cmd.load_len ? req_rx_byte[CW-1:0] : expected_ff;

      idx_in = idx_ff;
      if (cmd.emit_load) begin
         idx_in = status.emit_last ? '0 : idx_ff + CW'(1);
      end

      if (cmd.emit_load || cmd.err_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         expected_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         expected_ff  <= expected_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         frame_mem[count_ff[AW-1:0]] <= req_rx_byte;
      end
   end

   // result register doubles as the store read register
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_payload_ff <= (idx_ff < count_ff) ? frame_mem[idx_ff[AW-1:0]] : 8'd0;
         rsp_index_ff   <= idx_wide[IDX_W-1:0];
         rsp_last_ff    <= status.emit_last;
         rsp_error_ff   <= 1'b0;
      end else if (cmd.err_load) begin
         rsp_payload_ff <= 8'd0;
         rsp_index_ff   <= '0;
         rsp_last_ff    <= 1'b1;
         rsp_error_ff   <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_payload_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_last_byte    = rsp_last_ff;
   assign rsp_frame_error  = rsp_error_ff;

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_load && cmd.err_load))
      else $error("frame byte and error result loaded together");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff < total)
      else $error("emit index past end of frame");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_last_ff && rsp_payload_ff == 8'd0))
      else $error("error result not marked as last zero byte");

endmodule

>>> rtl/triple_star_frame_deframer.sv
// ----------------------------------------------------------------------------
// triple_star_frame_deframer
// Finds frames of three or more '*' bytes, a length byte and that many
// payload bytes in a received byte stream and sends each frame out byte by
// byte, zero padded to eight bytes, with the last byte marked.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    req_rx_byte
//   rsp_     out        rsp_valid/rsp_ready    rsp_payload_byte, rsp_byte_index,
//                                              rsp_last_byte, rsp_frame_error
//
// - header, length and payload bytes can arrive back to back
// - a completed frame streams max(length, 8) results, one per cycle unless
//   stalled, from the single-port store; no request is taken while it streams
// - an oversize length gives one error result and the parser goes idle
// - synchronous active-high reset returns the parser to idle with no result
//   pending; the frame store needs no clearing
// - a stalled result holds in the output register; once three '*' bytes are
//   seen, every byte up to and including the length byte waits for that
//   register to free up, header and payload bytes are still taken
//
module triple_star_frame_deframer
   import tsfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
   input  logic             clock,
   input  logic             reset,

   // received byte requests
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,

   // frame byte results
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic [IDX_W-1:0] rsp_byte_index,
   output logic             rsp_last_byte,
   output logic             rsp_frame_error
);

   // command and status between the sequencer and the datapath
   cmd_type    cmd;
   status_type status;

   // header, length and payload parsing plus emit sequencing
   tsfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame store, counters and the registered result stage
   tsfd_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_frame_error  (rsp_frame_error)
   );

endmodule
